### sv/spectrum_code_unpacker_assert.svh
// Assertion macros for the spectrum code unpacker checker.
// Expects clk and arst_n in the scope of use.
`ifndef SPECTRUM_CODE_UNPACKER_ASSERT_SVH
`define SPECTRUM_CODE_UNPACKER_ASSERT_SVH

// same-cycle implication
`define SCU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/scu_pkg.sv
// Shared types, constants and helpers for the spectrum code unpacker.
// No dependencies.
`timescale 1ns / 1ps

package scu_pkg;

	localparam int NUM_UNIT_SLOTS = 34;
	localparam int MAX_RESULTS    = 8;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	localparam logic CFG_UNIT_COUNT = 1'b0;
	localparam logic CFG_PASS_MODE  = 1'b1;

	// lines per unit
	localparam logic [4:0] UNIT_WIDTH [NUM_UNIT_SLOTS] = '{
		5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
		5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
		5'd8, 5'd8, 5'd8, 5'd8,
		5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16};

	// first line of each unit
	localparam logic [7:0] UNIT_START [NUM_UNIT_SLOTS] = '{
		8'd0, 8'd2, 8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14,
		8'd16, 8'd20, 8'd24, 8'd28, 8'd32, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52,
		8'd56, 8'd60, 8'd64, 8'd72, 8'd80, 8'd88,
		8'd96, 8'd112, 8'd128, 8'd144, 8'd160, 8'd176, 8'd192, 8'd208, 8'd224, 8'd240};

	// ternary pair table, {a[1:0], b[1:0]}
	localparam logic [3:0] PAIR_TAB [8] = '{
		4'd0, 4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd10};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHECK,
		ST_EXTRACT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [4:0]       need;
		logic [2:0]       per;
		logic [3:0][15:0] vals;
	} dec_t;

	function automatic logic [4:0] word_len(input logic [3:0] prec);
		word_len = (prec == 4'd0) ? 5'd0 : 5'({1'b0, prec} + 5'd1);
	endfunction

endpackage

### sv/scu_prec_mem.sv
// Precision table memory: one write port, one registered read port.
// Uses no package items.
`timescale 1ns / 1ps

module scu_prec_mem #(
	parameter int DEPTH = 34,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [3:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [3:0]    rdata
);

	logic [3:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/scu_decoder.sv
// Shared extraction unit: aligns the next code in the bit buffer and decodes it.
// Depends on scu_pkg.
`timescale 1ns / 1ps

module scu_decoder (
	input  logic          pass_mode,
	input  logic [3:0]    prec,
	input  logic          narrow,
	input  logic [23:0]   bit_buf,
	input  logic [4:0]    bits_held,
	output scu_pkg::dec_t dec
);

	logic        code_unit;
	logic [23:0] aligned;
	logic [15:0] top16;
	logic [15:0] field;
	logic [3:0]  pv;
	logic [6:0]  q;
	logic [6:0]  r0;
	logic [6:0]  r1;
	logic [6:0]  r2;
	logic [1:0]  d0;
	logic [1:0]  d1;
	logic [1:0]  d2;
	logic [1:0]  d3;

	always_comb begin
		code_unit = !pass_mode && (prec == 4'd1);
		dec.need  = code_unit ? (narrow ? 5'd3 : 5'd7) : scu_pkg::word_len(prec);
		dec.per   = code_unit ? (narrow ? 3'd2 : 3'd4) : 3'd1;

		// left-align unread bits, code sits at the top
		aligned = bit_buf << (5'd24 - bits_held);
		top16   = aligned[23:8];
		field   = 16'($signed(top16) >>> (5'd16 - dec.need));

		pv = scu_pkg::PAIR_TAB[top16[15:13]];

		// base-3 digits by compare and subtract
		q  = top16[15:9];
		d0 = (q >= 7'd54) ? 2'd2 : ((q >= 7'd27) ? 2'd1 : 2'd0);
		r0 = q - ((d0 == 2'd2) ? 7'd54 : ((d0 == 2'd1) ? 7'd27 : 7'd0));
		d1 = (r0 >= 7'd18) ? 2'd2 : ((r0 >= 7'd9) ? 2'd1 : 2'd0);
		r1 = r0 - ((d1 == 2'd2) ? 7'd18 : ((d1 == 2'd1) ? 7'd9 : 7'd0));
		d2 = (r1 >= 7'd6) ? 2'd2 : ((r1 >= 7'd3) ? 2'd1 : 2'd0);
		r2 = r1 - ((d2 == 2'd2) ? 7'd6 : ((d2 == 2'd1) ? 7'd3 : 7'd0));
		d3 = r2[1:0];
		if (q >= 7'd81) begin
			// escape codes: every value +2
			d0 = 2'd3;
			d1 = 2'd3;
			d2 = 2'd3;
			d3 = 2'd3;
		end

		dec.vals = '0;
		if (code_unit && narrow) begin
			dec.vals[0] = {14'd0, pv[3:2]} - 16'd1;
			dec.vals[1] = {14'd0, pv[1:0]} - 16'd1;
		end else if (code_unit) begin
			dec.vals[0] = {14'd0, d0} - 16'd1;
			dec.vals[1] = {14'd0, d1} - 16'd1;
			dec.vals[2] = {14'd0, d2} - 16'd1;
			dec.vals[3] = {14'd0, d3} - 16'd1;
		end else begin
			dec.vals[0] = field;
		end
	end

endmodule

### sv/spectrum_code_unpacker.sv
// Spectrum code unpacker: one byte request a time, one decode unit under a sequencer.
// Byte: EXTRACT per code, EMIT per result, a last EXTRACT when no code fits;
// a unit entered adds FETCH, CHECK. Start: FETCH, CHECK per unit, EMIT if empty.
// Input is blocked while a request is being worked; the output register may still hold.
// Async reset clears control and config; the precision table is not cleared.
`timescale 1ns / 1ps

module spectrum_code_unpacker #(
	parameter int MAX_UNITS = 34
) (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [5:0]         unit_index,
	input  logic [3:0]         precision_code,
	input  logic [7:0]         stream_byte,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         coef_index,
	output logic signed [15:0] coef_value,
	output logic               coef_valid,
	output logic               pass_last,
	// config write port
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data
);

	localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

	scu_pkg::state_t state_q, state_d;

	// config
	logic [5:0]       unit_count_q;
	logic             pass_mode_q;

	// stream and position state
	logic [23:0]      buf_q;
	logic [4:0]       bits_q;
	logic [5:0]       cu_q;
	logic [4:0]       pos_q;
	logic             active_q;
	logic             start_q;    // scanning after a start request
	logic [3:0]       n_q;        // results from the current byte

	// decoded code waiting to go out
	logic [3:0][15:0] vals_q;
	logic [7:0]       base_q;
	logic [2:0]       cnt_q;
	logic [1:0]       k_q;
	logic             cvalid_q;
	logic             last_q;

	// output register
	logic             out_valid_q;
	logic [7:0]       coef_index_q;
	logic [15:0]      coef_value_q;
	logic             coef_valid_q;
	logic             pass_last_q;

	logic [3:0]       prec;
	scu_pkg::dec_t    dec;

	logic [5:0]       uc;
	logic [5:0]       ux;
	logic [4:0]       width;
	logic [7:0]       ustart;
	logic             narrow;
	logic             acc;
	logic             byte_ok;
	logic             ext_go;
	logic             unit_done;
	logic             cu_end;
	logic             emit_load;
	logic             emit_final;
	logic             mem_we;

	// unit count saturates at the table depth
	assign uc     = (unit_count_q > 6'(MAX_UNITS)) ? 6'(MAX_UNITS) : unit_count_q;
	assign ux     = (cu_q < 6'(scu_pkg::NUM_UNIT_SLOTS)) ? cu_q : 6'd0;
	assign width  = scu_pkg::UNIT_WIDTH[ux];
	assign ustart = scu_pkg::UNIT_START[ux];
	assign narrow = (width == 5'd2);

	assign in_ready = (state_q == scu_pkg::ST_IDLE);
	assign acc      = in_valid && in_ready;
	// a byte that would overflow the buffer is dropped
	assign byte_ok  = acc && (req_type == scu_pkg::REQ_BYTE) && active_q && (bits_q <= 5'd16);
	assign mem_we   = acc && (req_type == scu_pkg::REQ_WRITE) && (unit_index < 6'(MAX_UNITS));

	// next code fits in the buffer and in this byte's result budget
	assign ext_go = (dec.need != 5'd0) && (bits_q >= dec.need)
		&& (({1'b0, n_q} + {2'b0, dec.per}) <= 5'(scu_pkg::MAX_RESULTS));
	assign unit_done  = ({1'b0, pos_q} + {3'b0, dec.per}) >= {1'b0, width};
	assign cu_end     = (cu_q >= uc);
	assign emit_load  = !out_valid_q || out_ready;
	assign emit_final = (k_q == 2'(cnt_q - 3'd1));

	scu_prec_mem #(
		.DEPTH (MAX_UNITS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (unit_index[AW-1:0]),
		.wdata (precision_code),
		.raddr (cu_q[AW-1:0]),
		.rdata (prec)
	);

	scu_decoder u_dec (
		.pass_mode (pass_mode_q),
		.prec      (prec),
		.narrow    (narrow),
		.bit_buf   (buf_q),
		.bits_held (bits_q),
		.dec       (dec)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			scu_pkg::ST_IDLE: begin
				if (acc && (req_type == scu_pkg::REQ_START)) begin
					state_d = scu_pkg::ST_FETCH;
				end else if (byte_ok) begin
					state_d = scu_pkg::ST_EXTRACT;
				end
			end
			scu_pkg::ST_FETCH: begin
				state_d = scu_pkg::ST_CHECK;
			end
			scu_pkg::ST_CHECK: begin
				if (cu_end) begin
					state_d = scu_pkg::ST_EMIT;
				end else if (dec.need == 5'd0) begin
					state_d = scu_pkg::ST_FETCH;    // skip empty unit
				end else if (start_q) begin
					state_d = scu_pkg::ST_IDLE;
				end else begin
					state_d = scu_pkg::ST_EMIT;
				end
			end
			scu_pkg::ST_EXTRACT: begin
				if (!ext_go) begin
					state_d = scu_pkg::ST_IDLE;
				end else if (unit_done) begin
					state_d = scu_pkg::ST_FETCH;    // find next unit before flagging last
				end else begin
					state_d = scu_pkg::ST_EMIT;
				end
			end
			scu_pkg::ST_EMIT: begin
				if (emit_load && emit_final) begin
					state_d = active_q ? scu_pkg::ST_EXTRACT : scu_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scu_pkg::ST_IDLE;
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_count_q <= 6'd34;
			pass_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				scu_pkg::CFG_UNIT_COUNT: unit_count_q <= cfg_data;
				scu_pkg::CFG_PASS_MODE:  pass_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stream and position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q    <= '0;
			bits_q   <= '0;
			cu_q     <= '0;
			pos_q    <= '0;
			active_q <= 1'b0;
			start_q  <= 1'b0;
			n_q      <= '0;
			cnt_q    <= 3'd1;
			k_q      <= '0;
			cvalid_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				scu_pkg::ST_IDLE: begin
					if (acc && (req_type == scu_pkg::REQ_START)) begin
						// start on a byte boundary; abandons any pass in flight
						buf_q    <= '0;
						bits_q   <= '0;
						active_q <= 1'b0;
						cu_q     <= '0;
						pos_q    <= '0;
						start_q  <= 1'b1;
					end else if (byte_ok) begin
						buf_q   <= {buf_q[15:0], stream_byte};
						bits_q  <= bits_q + 5'd8;
						n_q     <= '0;
						start_q <= 1'b0;
					end
				end
				scu_pkg::ST_CHECK: begin
					if (cu_end) begin
						active_q <= 1'b0;
						buf_q    <= '0;
						bits_q   <= '0;
						last_q   <= 1'b1;
						if (start_q) begin
							// empty pass: a single marker result
							cnt_q    <= 3'd1;
							k_q      <= '0;
							cvalid_q <= 1'b0;
						end
					end else if (dec.need == 5'd0) begin
						cu_q <= cu_q + 6'd1;
					end else if (start_q) begin
						active_q <= 1'b1;
					end else begin
						last_q <= 1'b0;
					end
				end
				scu_pkg::ST_EXTRACT: begin
					if (ext_go) begin
						cnt_q    <= dec.per;
						k_q      <= '0;
						cvalid_q <= 1'b1;
						last_q   <= 1'b0;
						bits_q   <= bits_q - dec.need;
						n_q      <= n_q + {1'b0, dec.per};
						if (unit_done) begin
							cu_q  <= cu_q + 6'd1;
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + {2'b0, dec.per};
						end
					end
				end
				scu_pkg::ST_EMIT: begin
					if (emit_load) begin
						k_q <= k_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// decoded values and their base line: payload, no reset
	always_ff @(posedge clk) begin
		if (state_q == scu_pkg::ST_EXTRACT && ext_go) begin
			vals_q <= dec.vals;
			base_q <= ustart + {3'b0, pos_q};
		end else if (state_q == scu_pkg::ST_CHECK && cu_end && start_q) begin
			vals_q <= '0;
			base_q <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == scu_pkg::ST_EMIT && emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == scu_pkg::ST_EMIT && emit_load) begin
			coef_index_q <= base_q + {6'b0, k_q};
			coef_value_q <= vals_q[k_q];
			coef_valid_q <= cvalid_q;
			pass_last_q  <= last_q && emit_final;
		end
	end

	assign out_valid  = out_valid_q;
	assign coef_index = coef_index_q;
	assign coef_value = $signed(coef_value_q);
	assign coef_valid = coef_valid_q;
	assign pass_last  = pass_last_q;

endmodule

### sv/scu_checker.sv
// Port-level checker for spectrum_code_unpacker, bound to the top level.
// Depends on scu_pkg and spectrum_code_unpacker_assert.svh.
`timescale 1ns / 1ps
`include "spectrum_code_unpacker_assert.svh"

module scu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         req_type,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         coef_index,
	input logic signed [15:0] coef_value,
	input logic               coef_valid,
	input logic               pass_last
);

	// stalled result holds
	`SCU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coef_index) && $stable(coef_value) && $stable(coef_valid) && $stable(pass_last), "stalled result changed")

	// empty-pass marker is zero and ends the pass
	`SCU_ASSERT_SAME(a_marker, out_valid && !coef_valid, pass_last && coef_index == 8'd0 && coef_value == 16'sd0, "bad empty-pass marker")

	// table writes never block the next request
	`SCU_ASSERT_NEXT(a_write_ready, in_valid && in_ready && req_type == scu_pkg::REQ_WRITE, in_ready, "not ready after table write")

	// unknown requests are dropped at once
	`SCU_ASSERT_NEXT(a_unknown_ready, in_valid && in_ready && req_type != scu_pkg::REQ_WRITE && req_type != scu_pkg::REQ_BYTE && req_type != scu_pkg::REQ_START, in_ready, "not ready after unknown request")

endmodule

bind spectrum_code_unpacker scu_checker u_scu_checker (.*);
